@@ sv/edsamp_pkg.sv @@
// ----------------------------------------------------------------------------
// edsamp_pkg
// Shared sizes, status codes and register indexes of the edge sampler.
// ----------------------------------------------------------------------------
package edsamp_pkg;

  localparam int VERTEX_COUNT  = 65536;
  localparam int EDGE_CAPACITY = 4096;

  localparam int VID_W   = 16;
  localparam int KEY_W   = 2 * VID_W;
  localparam int ROW_W   = 32;
  localparam int BIT_AW  = $clog2(ROW_W);
  localparam int ROW_CNT = VERTEX_COUNT / ROW_W;
  localparam int ROW_AW  = $clog2(ROW_CNT);
  localparam int EDGE_AW = $clog2(EDGE_CAPACITY);
  localparam int EDGE_CW = 13;
  localparam int NODE_CW = 17;
  localparam int STAT_W  = 3;

  localparam logic [STAT_W-1:0] ST_KEPT     = 3'd0;
  localparam logic [STAT_W-1:0] ST_REJECTED = 3'd1;
  localparam logic [STAT_W-1:0] ST_SELFLOOP = 3'd2;
  localparam logic [STAT_W-1:0] ST_DUP      = 3'd3;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd4;

  localparam logic REG_PROB_ISOLATED = 1'b0;
  localparam logic REG_PROB_TOUCHING = 1'b1;

endpackage

@@ sv/edsamp_ram.sv @@
// ----------------------------------------------------------------------------
// edsamp_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module edsamp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/edge_stream_degree_sampler.sv @@
// ----------------------------------------------------------------------------
// edge_stream_degree_sampler
// Streaming edge sampler with duplicate check and visited-vertex counting.
// ----------------------------------------------------------------------------
// One word in, one word out. After reset the visited bitmap is cleared one
// 32-bit row per cycle, all 2048 rows, during which no word is accepted (the
// probability registers can be written during the clear). A self loop goes
// straight to the result. Any other edge is checked against every stored edge,
// one edge store read per cycle, then the two bitmap rows are read and, for a
// kept edge, updated; a kept edge whose second endpoint sits in another bitmap
// row that did not hold it yet needs its own write-back of that row.
// The next word is accepted while the previous result waits.
module edge_stream_degree_sampler (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [2:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [edsamp_pkg::VID_W-1:0]       first_vertex,
  input  logic [edsamp_pkg::VID_W-1:0]       second_vertex,
  input  logic [15:0]                        coin,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               kept,
  output logic [edsamp_pkg::STAT_W-1:0]      status,
  output logic [edsamp_pkg::EDGE_CW-1:0]     sampled_edges,
  output logic [edsamp_pkg::NODE_CW-1:0]     sampled_nodes
);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_VRA  = 3'd3;
  localparam logic [2:0] S_VRB  = 3'd4;
  localparam logic [2:0] S_VDEC = 3'd5;
  localparam logic [2:0] S_VWB  = 3'd6;
  localparam logic [2:0] S_EMIT = 3'd7;

  logic [2:0]                        state;
  logic [15:0]                       prob_isolated;
  logic [15:0]                       prob_touching;
  logic [edsamp_pkg::VID_W-1:0]      lo_v;
  logic [edsamp_pkg::VID_W-1:0]      hi_v;
  logic [15:0]                       coin_r;
  logic [edsamp_pkg::STAT_W-1:0]     stat_r;
  logic [edsamp_pkg::EDGE_CW-1:0]    edge_total;
  logic [edsamp_pkg::NODE_CW-1:0]    node_total;
  logic [edsamp_pkg::EDGE_CW-1:0]    scan_addr;
  logic                              pend;
  logic [edsamp_pkg::ROW_AW-1:0]     clr_addr;
  logic [edsamp_pkg::ROW_W-1:0]      row_a;
  logic [edsamp_pkg::ROW_W-1:0]      row_b;

  logic                              cfg_wr;
  logic                              in_acc;
  logic [edsamp_pkg::KEY_W-1:0]      key;
  logic                              e_we;
  logic [edsamp_pkg::KEY_W-1:0]      e_rdata;
  logic                              v_we;
  logic [edsamp_pkg::ROW_AW-1:0]     v_waddr;
  logic [edsamp_pkg::ROW_W-1:0]      v_wdata;
  logic [edsamp_pkg::ROW_AW-1:0]     v_raddr;
  logic [edsamp_pkg::ROW_W-1:0]      v_rdata;
  logic [edsamp_pkg::ROW_AW-1:0]     a_row;
  logic [edsamp_pkg::ROW_AW-1:0]     b_row;
  logic [edsamp_pkg::BIT_AW-1:0]     a_bit;
  logic [edsamp_pkg::BIT_AW-1:0]     b_bit;
  logic                              same_row;
  logic                              has_a;
  logic                              has_b;
  logic                              pass;
  logic                              full;
  logic                              keep;
  logic [edsamp_pkg::ROW_W-1:0]      row_a_set;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && (paddr[1:0] == 2'b00);
  assign prdata   = (paddr[2] == edsamp_pkg::REG_PROB_ISOLATED) ? {16'd0, prob_isolated}
                                                                : {16'd0, prob_touching};
  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign key      = {lo_v, hi_v};

  assign a_row    = lo_v[edsamp_pkg::VID_W-1:edsamp_pkg::BIT_AW];
  assign b_row    = hi_v[edsamp_pkg::VID_W-1:edsamp_pkg::BIT_AW];
  assign a_bit    = lo_v[edsamp_pkg::BIT_AW-1:0];
  assign b_bit    = hi_v[edsamp_pkg::BIT_AW-1:0];
  assign same_row = (a_row == b_row);
  assign has_a    = row_a[a_bit];
  assign has_b    = v_rdata[b_bit];
  assign pass     = coin_r <= ((has_a || has_b) ? prob_touching : prob_isolated);
  assign full     = (edge_total == edsamp_pkg::EDGE_CW'(edsamp_pkg::EDGE_CAPACITY));
  assign keep     = (state == S_VDEC) && pass && !full;

  always_comb begin
    row_a_set = row_a | (edsamp_pkg::ROW_W'(1) << a_bit);
    if (same_row) begin
      row_a_set = row_a_set | (edsamp_pkg::ROW_W'(1) << b_bit);
    end
  end

  assign e_we    = keep;
  assign v_raddr = (state == S_VRA) ? a_row : b_row;

  always_comb begin
    v_we    = 1'b0;
    v_waddr = a_row;
    v_wdata = row_a_set;
    if (state == S_CLR) begin
      v_we    = 1'b1;
      v_waddr = clr_addr;
      v_wdata = '0;
    end else if (keep) begin
      v_we = 1'b1;
    end else if (state == S_VWB) begin
      v_we    = 1'b1;
      v_waddr = b_row;
      v_wdata = row_b;
    end
  end

  edsamp_ram #(
    .WIDTH (edsamp_pkg::KEY_W),
    .DEPTH (edsamp_pkg::EDGE_CAPACITY)
  ) u_edge_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (edge_total[edsamp_pkg::EDGE_AW-1:0]),
    .wdata (key),
    .raddr (scan_addr[edsamp_pkg::EDGE_AW-1:0]),
    .rdata (e_rdata)
  );

  edsamp_ram #(
    .WIDTH (edsamp_pkg::ROW_W),
    .DEPTH (edsamp_pkg::ROW_CNT)
  ) u_visit_ram (
    .clk   (clk),
    .we    (v_we),
    .waddr (v_waddr),
    .wdata (v_wdata),
    .raddr (v_raddr),
    .rdata (v_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      prob_isolated <= 16'hFFFF;
      prob_touching <= 16'hFFFF;
    end else if (cfg_wr) begin
      if (paddr[2] == edsamp_pkg::REG_PROB_ISOLATED) begin
        prob_isolated <= pwdata[15:0];
      end else begin
        prob_touching <= pwdata[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLR;
      clr_addr   <= '0;
      edge_total <= '0;
      node_total <= '0;
      out_valid  <= 1'b0;
      pend       <= 1'b0;
      scan_addr  <= '0;
    end else begin
      // S_EMIT drives out_valid itself
      if (out_valid && !out_stall && (state != S_EMIT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == edsamp_pkg::ROW_AW'(edsamp_pkg::ROW_CNT - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            coin_r    <= coin;
            scan_addr <= '0;
            pend      <= 1'b0;
            if (first_vertex < second_vertex) begin
              lo_v <= first_vertex;
              hi_v <= second_vertex;
            end else begin
              lo_v <= second_vertex;
              hi_v <= first_vertex;
            end
            if (first_vertex == second_vertex) begin
              stat_r <= edsamp_pkg::ST_SELFLOOP;
              state  <= S_EMIT;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // compare the word read last cycle while issuing the next read
          if (pend && (e_rdata == key)) begin
            stat_r <= edsamp_pkg::ST_DUP;
            state  <= S_EMIT;
          end else if (scan_addr < edge_total) begin
            scan_addr <= scan_addr + 1'b1;
            pend      <= 1'b1;
          end else begin
            pend  <= 1'b0;
            state <= S_VRA;
          end
        end
        S_VRA: begin
          state <= S_VRB;
        end
        S_VRB: begin
          row_a <= v_rdata;
          state <= S_VDEC;
        end
        S_VDEC: begin
          row_b <= v_rdata | (edsamp_pkg::ROW_W'(1) << b_bit);
          state <= S_EMIT;
          if (!pass) begin
            stat_r <= edsamp_pkg::ST_REJECTED;
          end else if (full) begin
            stat_r <= edsamp_pkg::ST_FULL;
          end else begin
            stat_r     <= edsamp_pkg::ST_KEPT;
            edge_total <= edge_total + 1'b1;
            node_total <= node_total + edsamp_pkg::NODE_CW'(!has_a)
                                     + edsamp_pkg::NODE_CW'(!has_b);
            if (!same_row && !has_b) begin
              state <= S_VWB;
            end
          end
        end
        S_VWB: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid || !out_stall) begin
            out_valid     <= 1'b1;
            kept          <= (stat_r == edsamp_pkg::ST_KEPT);
            status        <= stat_r;
            sampled_edges <= edge_total;
            sampled_nodes <= node_total;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ sv/edsamp_checker.sv @@
// ----------------------------------------------------------------------------
// edsamp_checker
// Port-level checks of the edge sampler result stream.
// ----------------------------------------------------------------------------
module edsamp_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic                           kept,
  input logic [edsamp_pkg::STAT_W-1:0]  status,
  input logic [edsamp_pkg::EDGE_CW-1:0] sampled_edges,
  input logic [edsamp_pkg::NODE_CW-1:0] sampled_nodes
);

  a_kept_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (kept == (status == edsamp_pkg::ST_KEPT)))
    else $error("kept flag disagrees with status");

  a_edges_cap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (sampled_edges <= edsamp_pkg::EDGE_CW'(edsamp_pkg::EDGE_CAPACITY)))
    else $error("edge count beyond capacity");

  a_nodes_bound: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kept) |-> (sampled_nodes != '0)
                            && (sampled_nodes <= {sampled_edges, 1'b0}))
    else $error("node count inconsistent with edge count");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid && $stable(status) && $stable(sampled_nodes))
    else $error("stalled word changed");

endmodule

bind edge_stream_degree_sampler edsamp_checker u_edsamp_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .kept          (kept),
  .status        (status),
  .sampled_edges (sampled_edges),
  .sampled_nodes (sampled_nodes)
);

@@ dv/edge_stream_degree_sampler_test.sv @@
// ----------------------------------------------------------------------------
// edge_stream_degree_sampler_test
// Self-checking bench for the edge sampler. Edges are driven through the
// valid/stall input with random gaps. The probability registers are written
// over APB while the block is idle. Each result word is compared with a
// scoreboard that mirrors the visited bitmap, the edge store and both counts.
// ----------------------------------------------------------------------------
module edge_stream_degree_sampler_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic                            kept;
    logic [edsamp_pkg::STAT_W-1:0]   status;
    logic [edsamp_pkg::EDGE_CW-1:0]  edges;
    logic [edsamp_pkg::NODE_CW-1:0]  nodes;
  } sample_t;

  logic clk, rst;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;
  logic in_valid, in_stall, out_valid, out_stall;
  logic [edsamp_pkg::VID_W-1:0] first_vertex, second_vertex;
  logic [15:0] coin;
  logic kept;
  logic [edsamp_pkg::STAT_W-1:0] status;
  logic [edsamp_pkg::EDGE_CW-1:0] sampled_edges;
  logic [edsamp_pkg::NODE_CW-1:0] sampled_nodes;

  edge_stream_degree_sampler u_dut (.*);

  // scoreboard state
  bit visited [edsamp_pkg::VERTEX_COUNT];
  bit stored_keys [bit [edsamp_pkg::KEY_W-1:0]];
  int unsigned edge_count, node_count;
  logic [15:0] p_isolated, p_touching;
  sample_t pending_q[$];

  int errors;
  int unsigned cycle_cnt;
  bit gaps_on;
  bit stall_on;
  bit hold_req;
  int hold_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic sample_t predict_edge(logic [15:0] a, logic [15:0] b, logic [15:0] c);
    sample_t r;
    logic [15:0] lo, hi;
    logic [edsamp_pkg::KEY_W-1:0] key;
    bit has_lo, has_hi;
    logic [15:0] prob;
    r.kept = 1'b0;
    if (a == b) begin
      r.status = edsamp_pkg::ST_SELFLOOP;
    end else begin
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      key = {lo, hi};
      if (stored_keys.exists(key)) begin
        r.status = edsamp_pkg::ST_DUP;
      end else begin
        has_lo = visited[lo];
        has_hi = visited[hi];
        prob = (has_lo || has_hi) ? p_touching : p_isolated;
        if (c > prob) begin
          r.status = edsamp_pkg::ST_REJECTED;
        end else if (edge_count >= edsamp_pkg::EDGE_CAPACITY) begin
          r.status = edsamp_pkg::ST_FULL;
        end else begin
          stored_keys[key] = 1'b1;
          edge_count++;
          if (!has_lo) begin
            visited[lo] = 1'b1;
            node_count++;
          end
          if (!has_hi && !visited[hi]) begin
            visited[hi] = 1'b1;
            node_count++;
          end
          r.kept = 1'b1;
          r.status = edsamp_pkg::ST_KEPT;
        end
      end
    end
    r.edges = (edge_count > 8191) ? 13'd8191 : edge_count[edsamp_pkg::EDGE_CW-1:0];
    r.nodes = (node_count > 131071) ? 17'd131071 : node_count[edsamp_pkg::NODE_CW-1:0];
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    sample_t exp_s;
    if (!rst && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected word kept=%0d status=%0d edges=%0d nodes=%0d",
                 $time, kept, status, sampled_edges, sampled_nodes);
        errors++;
      end else begin
        exp_s = pending_q.pop_front();
        if (kept !== exp_s.kept) begin
          $display("%0t: kept exp %0d got %0d", $time, exp_s.kept, kept);
          errors++;
        end
        if (status !== exp_s.status) begin
          $display("%0t: status exp %0d got %0d", $time, exp_s.status, status);
          errors++;
        end
        if (sampled_edges !== exp_s.edges) begin
          $display("%0t: sampled_edges exp %0d got %0d", $time, exp_s.edges, sampled_edges);
          errors++;
        end
        if (sampled_nodes !== exp_s.nodes) begin
          $display("%0t: sampled_nodes exp %0d got %0d", $time, exp_s.nodes, sampled_nodes);
          errors++;
        end
      end
    end
  end

  // receiver stall, with an optional long hold-off
  always @(posedge clk) begin
    int r;
    r = $urandom_range(0, 9);
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_on) begin
      out_stall <= (r < 3);
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (!gaps_on || r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_edge(logic [15:0] a, logic [15:0] b, logic [15:0] c);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    first_vertex <= a;
    second_vertex <= b;
    coin <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_q.push_back(predict_edge(a, b, c));
  endtask

  task automatic stop_sending();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (pending_q.size() != 0) @(posedge clk);
    // a word may still be in the search loop
    repeat (edge_count + 40) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'h0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == edsamp_pkg::REG_PROB_ISOLATED) p_isolated = value;
    else p_touching = value;
  endtask

  task automatic set_probs(logic [15:0] iso, logic [15:0] tch);
    stop_sending();
    wait_drained();
    write_reg(edsamp_pkg::REG_PROB_ISOLATED, iso);
    write_reg(edsamp_pkg::REG_PROB_TOUCHING, tch);
  endtask

  task automatic test_special_cases();
    set_probs(16'hFFFF, 16'hFFFF);
    send_edge(16'h0000, 16'h0000, 16'h0000);
    send_edge(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_edge(16'hFFFF, 16'h0000, 16'h0000);
    send_edge(16'h0000, 16'hFFFF, 16'hFFFF);
    send_edge(16'h0001, 16'h0002, 16'hFFFF);
    send_edge(16'h0002, 16'h0001, 16'h0000);
    send_edge(16'h8000, 16'h7FFF, 16'h1234);
  endtask

  task automatic test_probability_edges();
    set_probs(16'h0000, 16'hFFFF);
    send_edge(16'h0100, 16'h0101, 16'h0001);
    send_edge(16'h0102, 16'h0103, 16'h0000);
    send_edge(16'h0102, 16'h0200, 16'hFFFF);
    send_edge(16'h0300, 16'h0301, 16'h0000);
    set_probs(16'hFFFF, 16'h0000);
    send_edge(16'h0400, 16'h0401, 16'hFFFF);
    send_edge(16'h0400, 16'h0402, 16'h0001);
    send_edge(16'h0400, 16'h0403, 16'h0000);
    send_edge(16'h0500, 16'h0501, 16'hFFFE);
    set_probs(16'h8000, 16'h8000);
    send_edge(16'h0600, 16'h0601, 16'h8000);
    send_edge(16'h0602, 16'h0603, 16'h8001);
    send_edge(16'h0601, 16'h0604, 16'h8001);
  endtask

  function automatic logic [15:0] pick_vertex();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return 16'(16'h1000 + $urandom_range(0, 47));
    return 16'($urandom_range(0, 16'hFFFF));
  endfunction

  task automatic random_burst(int n);
    logic [15:0] a, b;
    repeat (n) begin
      a = pick_vertex();
      b = ($urandom_range(0, 19) == 0) ? a : pick_vertex();
      send_edge(a, b, 16'($urandom_range(0, 16'hFFFF)));
    end
  endtask

  task automatic test_random();
    int phase;
    logic [15:0] iso, tch;
    for (phase = 0; phase < 6; phase++) begin
      iso = (phase == 1) ? 16'h0000 : 16'($urandom_range(0, 16'hFFFF));
      tch = (phase == 2) ? 16'hFFFF : 16'($urandom_range(0, 16'hFFFF));
      set_probs(iso, tch);
      gaps_on = (phase != 3);
      stall_on = (phase != 4);
      random_burst(65);
    end
    gaps_on = 1'b1;
    stall_on = 1'b1;
  endtask

  task automatic test_backpressure();
    set_probs(16'hC000, 16'hC000);
    hold_req = 1'b1;
    gaps_on = 1'b0;
    random_burst(12);
    gaps_on = 1'b1;
    // pause until every word is back, then resume
    stop_sending();
    wait_drained();
    random_burst(10);
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    first_vertex = '0;
    second_vertex = '0;
    coin = '0;
    out_stall = 1'b0;
    errors = 0;
    cycle_cnt = 0;
    gaps_on = 1'b1;
    stall_on = 1'b1;
    hold_req = 1'b0;
    hold_left = 0;
    edge_count = 0;
    node_count = 0;
    p_isolated = 16'hFFFF;
    p_touching = 16'hFFFF;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_special_cases();
    test_probability_edges();
    test_backpressure();
    test_random();
    stop_sending();
    wait_drained();
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/edsamp_pkg.sv
sv/edsamp_ram.sv
sv/edge_stream_degree_sampler.sv
sv/edsamp_checker.sv
dv/edge_stream_degree_sampler_test.sv
